[sv/edw_pkg.sv]
// ----------------------------------------------------------------------------
// edw_pkg
// Shared types, constants and width tables for the display width counter.
// ----------------------------------------------------------------------------
package edw_pkg;

   localparam int CP_BITS        = 21;
   localparam int CW_BITS        = 2;
   localparam int RUN_BITS       = 16;
   localparam int TOTAL_BITS_DEF = 16;
   localparam int AMB_COUNT      = 156;

   typedef logic [CP_BITS-1:0] cp_type;
   typedef logic [CW_BITS-1:0] cw_type;

   localparam cw_type WIDTH_NARROW = 2'd1;
   localparam cw_type WIDTH_WIDE   = 2'd2;

   typedef struct packed {
      cp_type lo;
      cp_type hi;
   } span_type;

   typedef struct packed {
      cw_type char_width;
      logic   ambiguous;
   } class_type;

   typedef struct packed {
      logic step;
      logic last;
   } acc_ctl_type;

   localparam span_type AMB_TABLE [AMB_COUNT] = '{
      '{21'h000A1,21'h000A1}, '{21'h000A4,21'h000A4}, '{21'h000A7,21'h000A8},
      '{21'h000AA,21'h000AA}, '{21'h000AE,21'h000AE}, '{21'h000B0,21'h000B4},
      '{21'h000B6,21'h000BA}, '{21'h000BC,21'h000BF}, '{21'h000C6,21'h000C6},
      '{21'h000D0,21'h000D0}, '{21'h000D7,21'h000D8}, '{21'h000DE,21'h000E1},
      '{21'h000E6,21'h000E6}, '{21'h000E8,21'h000EA}, '{21'h000EC,21'h000ED},
      '{21'h000F0,21'h000F0}, '{21'h000F2,21'h000F3}, '{21'h000F7,21'h000FA},
      '{21'h000FC,21'h000FC}, '{21'h000FE,21'h000FE}, '{21'h00101,21'h00101},
      '{21'h00111,21'h00111}, '{21'h00113,21'h00113}, '{21'h0011B,21'h0011B},
      '{21'h00126,21'h00127}, '{21'h0012B,21'h0012B}, '{21'h00131,21'h00133},
      '{21'h00138,21'h00138}, '{21'h0013F,21'h00142}, '{21'h00144,21'h00144},
      '{21'h00148,21'h0014B}, '{21'h0014D,21'h0014D}, '{21'h00152,21'h00153},
      '{21'h00166,21'h00167}, '{21'h0016B,21'h0016B}, '{21'h001CE,21'h001CE},
      '{21'h001D0,21'h001D0}, '{21'h001D2,21'h001D2}, '{21'h001D4,21'h001D4},
      '{21'h001D6,21'h001D6}, '{21'h001D8,21'h001D8}, '{21'h001DA,21'h001DA},
      '{21'h001DC,21'h001DC}, '{21'h00251,21'h00251}, '{21'h00261,21'h00261},
      '{21'h002C4,21'h002C4}, '{21'h002C7,21'h002C7}, '{21'h002C9,21'h002CB},
      '{21'h002CD,21'h002CD}, '{21'h002D0,21'h002D0}, '{21'h002D8,21'h002DB},
      '{21'h002DD,21'h002DD}, '{21'h002DF,21'h002DF}, '{21'h00391,21'h003A1},
      '{21'h003A3,21'h003A9}, '{21'h003B1,21'h003C1}, '{21'h003C3,21'h003C9},
      '{21'h00401,21'h00401}, '{21'h00410,21'h0044F}, '{21'h00451,21'h00451},
      '{21'h02010,21'h02010}, '{21'h02013,21'h02016}, '{21'h02018,21'h02019},
      '{21'h0201C,21'h0201D}, '{21'h02020,21'h02022}, '{21'h02024,21'h02027},
      '{21'h02030,21'h02030}, '{21'h02032,21'h02033}, '{21'h02035,21'h02035},
      '{21'h0203B,21'h0203B}, '{21'h0203E,21'h0203E}, '{21'h02074,21'h02074},
      '{21'h0207F,21'h0207F}, '{21'h02081,21'h02084}, '{21'h020AC,21'h020AC},
      '{21'h02103,21'h02103}, '{21'h02105,21'h02105}, '{21'h02109,21'h02109},
      '{21'h02113,21'h02113}, '{21'h02116,21'h02116}, '{21'h02121,21'h02122},
      '{21'h02126,21'h02126}, '{21'h0212B,21'h0212B}, '{21'h02153,21'h02154},
      '{21'h0215B,21'h0215E}, '{21'h02160,21'h0216B}, '{21'h02170,21'h02179},
      '{21'h02190,21'h02199}, '{21'h021B8,21'h021B9}, '{21'h021D2,21'h021D2},
      '{21'h021D4,21'h021D4}, '{21'h021E7,21'h021E7}, '{21'h02200,21'h02200},
      '{21'h02202,21'h02203}, '{21'h02207,21'h02208}, '{21'h0220B,21'h0220B},
      '{21'h0220F,21'h0220F}, '{21'h02211,21'h02211}, '{21'h02215,21'h02215},
      '{21'h0221A,21'h0221A}, '{21'h0221D,21'h02220}, '{21'h02223,21'h02223},
      '{21'h02225,21'h02225}, '{21'h02227,21'h0222C}, '{21'h0222E,21'h0222E},
      '{21'h02234,21'h02237}, '{21'h0223C,21'h0223D}, '{21'h02248,21'h02248},
      '{21'h0224C,21'h0224C}, '{21'h02252,21'h02252}, '{21'h02260,21'h02261},
      '{21'h02264,21'h02267}, '{21'h0226A,21'h0226B}, '{21'h0226E,21'h0226F},
      '{21'h02282,21'h02283}, '{21'h02286,21'h02287}, '{21'h02295,21'h02295},
      '{21'h02299,21'h02299}, '{21'h022A5,21'h022A5}, '{21'h022BF,21'h022BF},
      '{21'h02312,21'h02312}, '{21'h02460,21'h024E9}, '{21'h024EB,21'h0254B},
      '{21'h02550,21'h02573}, '{21'h02580,21'h0258F}, '{21'h02592,21'h02595},
      '{21'h025A0,21'h025A1}, '{21'h025A3,21'h025A9}, '{21'h025B2,21'h025B3},
      '{21'h025B6,21'h025B7}, '{21'h025BC,21'h025BD}, '{21'h025C0,21'h025C1},
      '{21'h025C6,21'h025C8}, '{21'h025CB,21'h025CB}, '{21'h025CE,21'h025D1},
      '{21'h025E2,21'h025E5}, '{21'h025EF,21'h025EF}, '{21'h02605,21'h02606},
      '{21'h02609,21'h02609}, '{21'h0260E,21'h0260F}, '{21'h02614,21'h02615},
      '{21'h0261C,21'h0261C}, '{21'h0261E,21'h0261E}, '{21'h02640,21'h02640},
      '{21'h02642,21'h02642}, '{21'h02660,21'h02661}, '{21'h02663,21'h02665},
      '{21'h02667,21'h0266A}, '{21'h0266C,21'h0266D}, '{21'h0266F,21'h0266F},
      '{21'h0273D,21'h0273D}, '{21'h02776,21'h0277F}, '{21'h0E000,21'h0F8FF},
      '{21'h0FFFD,21'h0FFFD}, '{21'h0F0000,21'h0FFFFD}, '{21'h100000,21'h10FFFD}
   };

   function automatic logic in_amb_table(input cp_type cp);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < AMB_COUNT; i++) begin
         hit = hit | ((cp >= AMB_TABLE[i].lo) && (cp <= AMB_TABLE[i].hi));
      end
      return hit;
   endfunction

   function automatic logic in_wide_range(input cp_type cp);
      return ((cp >= 21'h01100) && (cp <= 21'h0115F)) ||
             (cp == 21'h02329) || (cp == 21'h0232A) ||
             ((cp >= 21'h02E80) && (cp <= 21'h0A4CF) && (cp != 21'h0303F)) ||
             ((cp >= 21'h0AC00) && (cp <= 21'h0D7A3)) ||
             ((cp >= 21'h0F900) && (cp <= 21'h0FAFF)) ||
             ((cp >= 21'h0FE30) && (cp <= 21'h0FE6F)) ||
             ((cp >= 21'h0FF00) && (cp <= 21'h0FF60)) ||
             ((cp >= 21'h0FFE0) && (cp <= 21'h0FFE6)) ||
             ((cp >= 21'h20000) && (cp <= 21'h2FFFD)) ||
             ((cp >= 21'h30000) && (cp <= 21'h3FFFD));
   endfunction

endpackage

[sv/edw_classify.sv]
// ----------------------------------------------------------------------------
// edw_classify
// Parallel range compares giving the column width and ambiguous flag.
// ----------------------------------------------------------------------------
module edw_classify (
   input  edw_pkg::cp_type    code_point,
   output edw_pkg::class_type cls
);

   logic amb;
   logic wide;

   always_comb begin
      amb  = edw_pkg::in_amb_table(code_point);
      wide = edw_pkg::in_wide_range(code_point);
      cls.ambiguous  = amb;
      cls.char_width = (amb || wide) ? edw_pkg::WIDTH_WIDE : edw_pkg::WIDTH_NARROW;
   end

endmodule

[sv/edw_accum.sv]
// ----------------------------------------------------------------------------
// edw_accum
// Saturating per-string width total, cleared after the last beat.
// ----------------------------------------------------------------------------
module edw_accum #(
   parameter int TOTAL_BITS = edw_pkg::TOTAL_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  edw_pkg::acc_ctl_type           ctl,
   input  edw_pkg::cw_type                char_width,
   output logic [edw_pkg::RUN_BITS-1:0]   running_width
);

   logic [TOTAL_BITS-1:0] total_ff;
   logic [TOTAL_BITS-1:0] total_in;
   logic [TOTAL_BITS:0]   sum_wide;
   logic [TOTAL_BITS-1:0] sum_sat;

   always_comb begin
      sum_wide = {1'b0, total_ff} + {{(TOTAL_BITS-1){1'b0}}, char_width};
      sum_sat  = sum_wide[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : sum_wide[TOTAL_BITS-1:0];
      running_width = edw_pkg::RUN_BITS'(sum_sat);
      total_in = total_ff;
      if (ctl.step) begin
         total_in = ctl.last ? '0 : sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
   end

endmodule

[sv/east_asian_display_width_counter.sv]
// ----------------------------------------------------------------------------
// east_asian_display_width_counter
// Takes one code point per beat and returns its display width (1 or 2), the
// East Asian ambiguous flag, and a saturating running total of the string
// that clears after the beat marked last. One beat is accepted every cycle
// while the result is not stalled; each result passes through an input
// register and a result register, with the total add as the only loop. A
// stalled result holds both stages without dropping a beat.
// ----------------------------------------------------------------------------
module east_asian_display_width_counter #(
   parameter int TOTAL_BITS = edw_pkg::TOTAL_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [edw_pkg::CP_BITS-1:0]   req_code_point,
   input  logic                          req_last_char,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [edw_pkg::CW_BITS-1:0]   rsp_char_width,
   output logic                          rsp_ambiguous_hit,
   output logic [edw_pkg::RUN_BITS-1:0]  rsp_running_width,
   output logic                          rsp_string_done
);

   logic                           in_valid_ff, in_valid_in;
   edw_pkg::cp_type                in_cp_ff;
   logic                           in_last_ff;
   logic                           out_valid_ff, out_valid_in;
   edw_pkg::cw_type                out_width_ff;
   logic                           out_amb_ff;
   logic [edw_pkg::RUN_BITS-1:0]   out_run_ff;
   logic                           out_done_ff;
   logic                           advance;
   logic                           load;
   edw_pkg::class_type             cls;
   edw_pkg::acc_ctl_type           acc_ctl;
   logic [edw_pkg::RUN_BITS-1:0]   run_next;

   edw_classify u_classify (
      .code_point (in_cp_ff),
      .cls        (cls)
   );

   edw_accum #(
      .TOTAL_BITS (TOTAL_BITS)
   ) u_accum (
      .clock         (clock),
      .reset         (reset),
      .ctl           (acc_ctl),
      .char_width    (cls.char_width),
      .running_width (run_next)
   );

   always_comb begin
      advance      = !out_valid_ff || !rsp_stall;
      req_stall    = in_valid_ff && !advance;
      load         = req_valid && !req_stall;
      in_valid_in  = req_stall ? in_valid_ff : req_valid;
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
      acc_ctl.step = advance && in_valid_ff;
      acc_ctl.last = in_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_cp_ff   <= req_code_point;
         in_last_ff <= req_last_char;
      end
      if (acc_ctl.step) begin
         out_width_ff <= cls.char_width;
         out_amb_ff   <= cls.ambiguous;
         out_run_ff   <= run_next;
         out_done_ff  <= in_last_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_char_width    = out_width_ff;
   assign rsp_ambiguous_hit = out_amb_ff;
   assign rsp_running_width = out_run_ff;
   assign rsp_string_done   = out_done_ff;

endmodule

[bench/east_asian_display_width_counter_tb.sv]
// ----------------------------------------------------------------------------
// east_asian_display_width_counter_tb
// Streams code points through the width counter and checks every result beat
// against an in-bench width model with its own range tables. The tests cover
// range and table edges, out-of-range and surrogate values, single-character
// strings, a long back-to-back string, and random text with sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
module east_asian_display_width_counter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int AMBIG_COUNT = 156;
   localparam int WIDE_COUNT  = 11;
   localparam logic [edw_pkg::TOTAL_BITS_DEF:0] TOTAL_MAX =
      {1'b0, {edw_pkg::TOTAL_BITS_DEF{1'b1}}};

   // {lo, hi} per entry, 24 bits each
   localparam logic [AMBIG_COUNT*48-1:0] AMBIG_SPANS = {
      48'h0000A1_0000A1, 48'h0000A4_0000A4, 48'h0000A7_0000A8, 48'h0000AA_0000AA,
      48'h0000AE_0000AE, 48'h0000B0_0000B4, 48'h0000B6_0000BA, 48'h0000BC_0000BF,
      48'h0000C6_0000C6, 48'h0000D0_0000D0, 48'h0000D7_0000D8, 48'h0000DE_0000E1,
      48'h0000E6_0000E6, 48'h0000E8_0000EA, 48'h0000EC_0000ED, 48'h0000F0_0000F0,
      48'h0000F2_0000F3, 48'h0000F7_0000FA, 48'h0000FC_0000FC, 48'h0000FE_0000FE,
      48'h000101_000101, 48'h000111_000111, 48'h000113_000113, 48'h00011B_00011B,
      48'h000126_000127, 48'h00012B_00012B, 48'h000131_000133, 48'h000138_000138,
      48'h00013F_000142, 48'h000144_000144, 48'h000148_00014B, 48'h00014D_00014D,
      48'h000152_000153, 48'h000166_000167, 48'h00016B_00016B, 48'h0001CE_0001CE,
      48'h0001D0_0001D0, 48'h0001D2_0001D2, 48'h0001D4_0001D4, 48'h0001D6_0001D6,
      48'h0001D8_0001D8, 48'h0001DA_0001DA, 48'h0001DC_0001DC, 48'h000251_000251,
      48'h000261_000261, 48'h0002C4_0002C4, 48'h0002C7_0002C7, 48'h0002C9_0002CB,
      48'h0002CD_0002CD, 48'h0002D0_0002D0, 48'h0002D8_0002DB, 48'h0002DD_0002DD,
      48'h0002DF_0002DF, 48'h000391_0003A1, 48'h0003A3_0003A9, 48'h0003B1_0003C1,
      48'h0003C3_0003C9, 48'h000401_000401, 48'h000410_00044F, 48'h000451_000451,
      48'h002010_002010, 48'h002013_002016, 48'h002018_002019, 48'h00201C_00201D,
      48'h002020_002022, 48'h002024_002027, 48'h002030_002030, 48'h002032_002033,
      48'h002035_002035, 48'h00203B_00203B, 48'h00203E_00203E, 48'h002074_002074,
      48'h00207F_00207F, 48'h002081_002084, 48'h0020AC_0020AC, 48'h002103_002103,
      48'h002105_002105, 48'h002109_002109, 48'h002113_002113, 48'h002116_002116,
      48'h002121_002122, 48'h002126_002126, 48'h00212B_00212B, 48'h002153_002154,
      48'h00215B_00215E, 48'h002160_00216B, 48'h002170_002179, 48'h002190_002199,
      48'h0021B8_0021B9, 48'h0021D2_0021D2, 48'h0021D4_0021D4, 48'h0021E7_0021E7,
      48'h002200_002200, 48'h002202_002203, 48'h002207_002208, 48'h00220B_00220B,
      48'h00220F_00220F, 48'h002211_002211, 48'h002215_002215, 48'h00221A_00221A,
      48'h00221D_002220, 48'h002223_002223, 48'h002225_002225, 48'h002227_00222C,
      48'h00222E_00222E, 48'h002234_002237, 48'h00223C_00223D, 48'h002248_002248,
      48'h00224C_00224C, 48'h002252_002252, 48'h002260_002261, 48'h002264_002267,
      48'h00226A_00226B, 48'h00226E_00226F, 48'h002282_002283, 48'h002286_002287,
      48'h002295_002295, 48'h002299_002299, 48'h0022A5_0022A5, 48'h0022BF_0022BF,
      48'h002312_002312, 48'h002460_0024E9, 48'h0024EB_00254B, 48'h002550_002573,
      48'h002580_00258F, 48'h002592_002595, 48'h0025A0_0025A1, 48'h0025A3_0025A9,
      48'h0025B2_0025B3, 48'h0025B6_0025B7, 48'h0025BC_0025BD, 48'h0025C0_0025C1,
      48'h0025C6_0025C8, 48'h0025CB_0025CB, 48'h0025CE_0025D1, 48'h0025E2_0025E5,
      48'h0025EF_0025EF, 48'h002605_002606, 48'h002609_002609, 48'h00260E_00260F,
      48'h002614_002615, 48'h00261C_00261C, 48'h00261E_00261E, 48'h002640_002640,
      48'h002642_002642, 48'h002660_002661, 48'h002663_002665, 48'h002667_00266A,
      48'h00266C_00266D, 48'h00266F_00266F, 48'h00273D_00273D, 48'h002776_00277F,
      48'h00E000_00F8FF, 48'h00FFFD_00FFFD, 48'h0F0000_0FFFFD, 48'h100000_10FFFD
   };

   // split around 303f, which stays narrow
   localparam logic [WIDE_COUNT*48-1:0] WIDE_SPANS = {
      48'h001100_00115F, 48'h002329_00232A, 48'h002E80_00303E, 48'h003040_00A4CF,
      48'h00AC00_00D7A3, 48'h00F900_00FAFF, 48'h00FE30_00FE6F, 48'h00FF00_00FF60,
      48'h00FFE0_00FFE6, 48'h020000_02FFFD, 48'h030000_03FFFD
   };

   typedef enum {PICK_EDGE, PICK_AMBIG, PICK_WIDE, PICK_LATIN, PICK_ANY} cp_pick_type;
   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   typedef struct packed {
      edw_pkg::cw_type              char_width;
      logic                         ambiguous_hit;
      logic [edw_pkg::RUN_BITS-1:0] running_width;
      logic                         string_done;
   } width_beat_type;

   logic                         clock;
   logic                         reset          = 1'b1;
   logic                         req_valid      = 1'b0;
   logic                         req_stall;
   edw_pkg::cp_type              req_code_point = '0;
   logic                         req_last_char  = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_stall      = 1'b0;
   edw_pkg::cw_type              rsp_char_width;
   logic                         rsp_ambiguous_hit;
   logic [edw_pkg::RUN_BITS-1:0] rsp_running_width;
   logic                         rsp_string_done;

   width_beat_type                     expected_widths[$];
   logic [edw_pkg::TOTAL_BITS_DEF-1:0] width_total = '0;
   int                                 error_count = 0;
   int                                 burst_left  = 0;
   bit                                 idle_on     = 1'b0;

   east_asian_display_width_counter dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_code_point    (req_code_point),
      .req_last_char     (req_last_char),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_char_width    (rsp_char_width),
      .rsp_ambiguous_hit (rsp_ambiguous_hit),
      .rsp_running_width (rsp_running_width),
      .rsp_string_done   (rsp_string_done)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic width_beat_type measure_char(input edw_pkg::cp_type cp,
                                                   input logic last);
      width_beat_type                   beat;
      logic                             amb;
      logic                             wide;
      logic [edw_pkg::TOTAL_BITS_DEF:0] sum;
      amb  = 1'b0;
      wide = 1'b0;
      for (int i = 0; i < AMBIG_COUNT; i++) begin
         if (cp >= AMBIG_SPANS[i*48+24 +: 24] && cp <= AMBIG_SPANS[i*48 +: 24]) amb = 1'b1;
      end
      for (int i = 0; i < WIDE_COUNT; i++) begin
         if (cp >= WIDE_SPANS[i*48+24 +: 24] && cp <= WIDE_SPANS[i*48 +: 24]) wide = 1'b1;
      end
      beat.char_width    = (amb || wide) ? edw_pkg::WIDTH_WIDE : edw_pkg::WIDTH_NARROW;
      beat.ambiguous_hit = amb;
      sum = width_total + beat.char_width;
      if (sum > TOTAL_MAX) sum = TOTAL_MAX;
      beat.running_width = sum[edw_pkg::RUN_BITS-1:0];
      beat.string_done   = last;
      width_total = last ? '0 : sum[edw_pkg::TOTAL_BITS_DEF-1:0];
      return beat;
   endfunction

   function automatic edw_pkg::cp_type pick_code_point();
      cp_pick_type     kind;
      int              idx;
      logic [47:0]     span;
      logic [23:0]     lo;
      logic [23:0]     hi;
      edw_pkg::cp_type cp;
      kind = cp_pick_type'($urandom_range(0, 4));
      idx  = $urandom_range(0, AMBIG_COUNT - 1);
      span = AMBIG_SPANS[idx*48 +: 48];
      if (kind == PICK_WIDE || (kind == PICK_EDGE && $urandom_range(0, 1) == 1)) begin
         idx  = $urandom_range(0, WIDE_COUNT - 1);
         span = WIDE_SPANS[idx*48 +: 48];
      end
      lo = span[47:24];
      hi = span[23:0];
      case (kind)
         PICK_EDGE: begin
            case ($urandom_range(0, 3))
               0:       cp = edw_pkg::cp_type'(lo - 24'd1);
               1:       cp = edw_pkg::cp_type'(lo);
               2:       cp = edw_pkg::cp_type'(hi);
               default: cp = edw_pkg::cp_type'(hi + 24'd1);
            endcase
         end
         PICK_AMBIG, PICK_WIDE: cp = edw_pkg::cp_type'(lo + $urandom_range(0, hi - lo));
         PICK_LATIN: cp = edw_pkg::cp_type'($urandom_range(0, 'h3FF));
         default: cp = edw_pkg::cp_type'($urandom());
      endcase
      return cp;
   endfunction

   task automatic send_char(input edw_pkg::cp_type cp, input logic last);
      int gap;
      if (idle_on && burst_left == 0) begin
         gap = $urandom_range(0, 7);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) burst_left--;
      req_valid      <= 1'b1;
      req_code_point <= cp;
      req_last_char  <= last;
      do @(posedge clock); while (req_stall);
      expected_widths.push_back(measure_char(cp, last));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_widths.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic test_range_edges();
      idle_on = 1'b1;
      send_char(21'h000000, 1'b0);
      send_char(21'h001100, 1'b0);
      send_char(21'h00115F, 1'b0);
      send_char(21'h001160, 1'b0);
      send_char(21'h002329, 1'b0);
      send_char(21'h00232A, 1'b0);
      send_char(21'h00303F, 1'b0);
      send_char(21'h003040, 1'b0);
      send_char(21'h00A4CF, 1'b0);
      send_char(21'h00AC00, 1'b0);
      send_char(21'h00D7A3, 1'b0);
      send_char(21'h00D800, 1'b0);
      send_char(21'h00DFFF, 1'b0);
      send_char(21'h00E000, 1'b0);
      send_char(21'h00FE30, 1'b0);
      send_char(21'h00FE6F, 1'b0);
      send_char(21'h00FE70, 1'b0);
      send_char(21'h00FFFD, 1'b0);
      send_char(21'h03FFFE, 1'b0);
      send_char(21'h10FFFF, 1'b0);
      send_char(21'h110000, 1'b0);
      send_char(21'h1FFFFF, 1'b1);
   endtask

   task automatic test_string_ends();
      send_char(21'h004E00, 1'b1);
      send_char(21'h000041, 1'b1);
      send_char(21'h10FFFD, 1'b0);
      send_char(21'h0000A1, 1'b1);
   endtask

   task automatic test_long_string();
      idle_on = 1'b0;
      for (int k = 0; k < 300; k++) begin
         send_char(edw_pkg::cp_type'(21'h004E00 + $urandom_range(0, 'h51FF)), 1'b0);
      end
      send_char(21'h00AC00, 1'b0);
      send_char(21'h000041, 1'b0);
      send_char(21'h03FFFD, 1'b1);
   endtask

   task automatic test_random_text();
      int sent;
      int len;
      bit paused;
      sent   = 0;
      paused = 1'b0;
      while (sent < 1620) begin
         idle_on = ($urandom_range(0, 3) != 0);
         len = ($urandom_range(0, 19) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
         for (int k = 0; k < len; k++) send_char(pick_code_point(), k == len - 1);
         sent += len;
         if (sent >= 800 && !paused) begin
            drain_results();
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      stall_mode_type mode;
      int             span_left;
      int             tick;
      tick = 0;
      forever begin
         mode      = stall_mode_type'($urandom_range(0, 3));
         span_left = $urandom_range(20, 300);
         repeat (span_left) begin
            @(posedge clock);
            tick++;
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:     rsp_stall <= ((tick % 5) < 2);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      width_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_widths.size() == 0) begin
            $error("result beat with no character pending");
            error_count++;
         end else begin
            want = expected_widths.pop_front();
            if (rsp_char_width !== want.char_width) begin
               $error("char_width: expected %0d, got %0d", want.char_width, rsp_char_width);
               error_count++;
            end
            if (rsp_ambiguous_hit !== want.ambiguous_hit) begin
               $error("ambiguous_hit: expected %0d, got %0d",
                      want.ambiguous_hit, rsp_ambiguous_hit);
               error_count++;
            end
            if (rsp_running_width !== want.running_width) begin
               $error("running_width: expected %0d, got %0d",
                      want.running_width, rsp_running_width);
               error_count++;
            end
            if (rsp_string_done !== want.string_done) begin
               $error("string_done: expected %0d, got %0d", want.string_done, rsp_string_done);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_range_edges();
      test_string_ends();
      test_long_string();
      test_random_text();
      drain_results();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[filelist.f]
sv/edw_pkg.sv
sv/edw_classify.sv
sv/edw_accum.sv
sv/east_asian_display_width_counter.sv
bench/east_asian_display_width_counter_tb.sv
